[sv/pclru_pkg.sv]
// ----------------------------------------------------------------------------
// pclru_pkg
// shared widths, codes and record types of the per-class lru list block
// ----------------------------------------------------------------------------
package pclru_pkg;

   localparam int NUM_SLOTS   = 1024;
   localparam int NUM_CLASSES = 64;
   localparam int TIME_BITS   = 32;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
   localparam int CLS_W  = $clog2(NUM_CLASSES);

   localparam int OP_W     = 2;
   localparam int IDX_W    = 10;
   localparam int ICLS_W   = 6;
   localparam int NOW_W    = 32;
   localparam int STATUS_W = 2;
   localparam int OUT_W    = 11;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PTR_W-1:0]       NIL          = PTR_W'(NUM_SLOTS);
   localparam logic [CSR_DATA_W-1:0]  INTERVAL_RST = CSR_DATA_W'(60);
   localparam logic [CSR_ADDR_W-1:0]  ADDR_UPDATE_INTERVAL = CSR_ADDR_W'(0);

   localparam logic [OP_W-1:0] OP_LINK   = 2'd0;
   localparam logic [OP_W-1:0] OP_UNLINK = 2'd1;
   localparam logic [OP_W-1:0] OP_TOUCH  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SKIPPED    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ALREADY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_LINKED = 2'd3;

   typedef struct packed {
      logic                 linked;
      logic [CLS_W-1:0]     cls;
      logic [TIME_BITS-1:0] stamp;
   } meta_type;

   typedef struct packed {
      logic [PTR_W-1:0] head;
      logic [PTR_W-1:0] tail;
      logic [PTR_W-1:0] size;
   } class_type;

endpackage

[sv/pclru_req_if.sv]
// ----------------------------------------------------------------------------
// pclru_req_if
// request channel: one list operation per beat
// ----------------------------------------------------------------------------
interface pclru_req_if;
   import pclru_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [IDX_W-1:0]    item_index;
   logic [ICLS_W-1:0]   item_class;
   logic [NOW_W-1:0]    now_time;

   modport source (output valid, output operation, output item_index,
                   output item_class, output now_time, input ready);
   modport sink   (input valid, input operation, input item_index,
                   input item_class, input now_time, output ready);
endinterface

[sv/pclru_rsp_if.sv]
// ----------------------------------------------------------------------------
// pclru_rsp_if
// response channel: status and class list summary per beat
// ----------------------------------------------------------------------------
interface pclru_rsp_if;
   import pclru_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OUT_W-1:0]    list_head;
   logic [OUT_W-1:0]    list_tail;
   logic [OUT_W-1:0]    list_count;

   modport source (output valid, output status, output list_head,
                   output list_tail, output list_count, input ready);
   modport sink   (input valid, input status, input list_head,
                   input list_tail, input list_count, output ready);
endinterface

[sv/pclru_ram.sv]
// ----------------------------------------------------------------------------
// pclru_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module pclru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/per_class_lru_list_top.sv]
// ----------------------------------------------------------------------------
// per_class_lru_list_top
// per size class doubly linked recency lists over a fixed slot pool
// ----------------------------------------------------------------------------
// After reset the block clears the slot and class memories and accepts
// no request meanwhile (register writes are taken). Each request then runs
// through a small sequencer over slot, link and class memories with one
// write port each: link and a moving touch pass S_RD, S_CLS, S_PUT, S_PUT2
// and S_OUT, while unlink, errors and skipped touches skip the put states,
// paced by the dependent pointer reads and writes through each write port.
// The next request is accepted once the response is loaded.
module per_class_lru_list_top (
   input  logic                              clock,
   input  logic                              reset,
   pclru_req_if.sink                         req_bus,
   pclru_rsp_if.source                       rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pclru_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pclru_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pclru_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import pclru_pkg::*;

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_CLS  = 3'd3;
   localparam logic [2:0] S_PUT  = 3'd4;
   localparam logic [2:0] S_PUT2 = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [SLOT_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [CLS_W-1:0]      icls_ff, icls_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [CSR_DATA_W-1:0] interval_ff, interval_in;
   logic [CLS_W-1:0]      rc_ff, rc_in;
   logic                  old_ff, old_in;
   class_type             base_ff, base_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   class_type             res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   class_type             rsp_ff, rsp_in;

   meta_type              meta_rd, meta_wd;
   logic                  meta_we;
   logic [SLOT_W-1:0]     meta_wa, slot_ra;
   logic [PTR_W-1:0]      next_rd, next_wd, prev_rd, prev_wd;
   logic                  next_we, prev_we;
   logic [SLOT_W-1:0]     next_wa, prev_wa;
   class_type             cls_rd, cls_wd;
   logic                  cls_we;
   logic [CLS_W-1:0]      cls_wa, cls_ra;

   logic [PTR_W-1:0]      s_ptr;
   logic [TIME_BITS-1:0]  limit;
   logic                  do_take, do_put;
   class_type             taken, put_val;
   logic                  csr_wr;

   pclru_ram #(.WIDTH($bits(meta_type)), .DEPTH(NUM_SLOTS)) u_meta (
      .clock(clock), .wr_en(meta_we), .wr_addr(meta_wa), .wr_data(meta_wd),
      .rd_addr(slot_ra), .rd_data(meta_rd));
   pclru_ram #(.WIDTH(PTR_W), .DEPTH(NUM_SLOTS)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(slot_ra), .rd_data(next_rd));
   pclru_ram #(.WIDTH(PTR_W), .DEPTH(NUM_SLOTS)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(slot_ra), .rd_data(prev_rd));
   pclru_ram #(.WIDTH($bits(class_type)), .DEPTH(NUM_CLASSES)) u_class (
      .clock(clock), .wr_en(cls_we), .wr_addr(cls_wa), .wr_data(cls_wd),
      .rd_addr(cls_ra), .rd_data(cls_rd));

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == ADDR_UPDATE_INTERVAL);
   assign csr_prdata = (csr_paddr == ADDR_UPDATE_INTERVAL) ? interval_ff : '0;

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.list_head  = OUT_W'(rsp_ff.head);
   assign rsp_bus.list_tail  = OUT_W'(rsp_ff.tail);
   assign rsp_bus.list_count = OUT_W'(rsp_ff.size);

   assign s_ptr   = PTR_W'(idx_ff);
   assign slot_ra = (state_ff == S_IDLE) ? SLOT_W'(req_bus.item_index) : idx_ff;
   assign cls_ra  = (state_ff == S_RD) ? rc_in : rc_ff;
   assign limit   = now_ff - TIME_BITS'(interval_ff);

   // unlink of this slot from the class entry just read
   always_comb begin
      taken.head = (cls_rd.head == s_ptr) ? next_rd : cls_rd.head;
      taken.tail = (cls_rd.tail == s_ptr) ? prev_rd : cls_rd.tail;
      taken.size = (cls_rd.size != '0) ? cls_rd.size - PTR_W'(1) : cls_rd.size;
   end

   always_comb begin
      do_take = meta_rd.linked &&
                (op_ff == OP_UNLINK || (op_ff == OP_TOUCH && old_ff));
      do_put  = (op_ff == OP_LINK && !meta_rd.linked) ||
                (op_ff == OP_TOUCH && meta_rd.linked && old_ff);
      put_val.head = s_ptr;
      put_val.tail = (base_ff.tail >= NIL) ? s_ptr : base_ff.tail;
      put_val.size = base_ff.size + PTR_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      icls_in       = icls_ff;
      now_in        = now_ff;
      interval_in   = csr_wr ? csr_pwdata : interval_ff;
      rc_in         = rc_ff;
      old_in        = old_ff;
      base_in       = base_ff;
      res_status_in = res_status_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_in        = rsp_ff;
      meta_we = 1'b0;  meta_wa = idx_ff;  meta_wd = '0;
      next_we = 1'b0;  next_wa = idx_ff;  next_wd = base_ff.head;
      prev_we = 1'b0;  prev_wa = idx_ff;  prev_wd = NIL;
      cls_we  = 1'b0;  cls_wa  = rc_ff;   cls_wd  = put_val;

      unique case (state_ff)
         S_CLR: begin
            meta_we = 1'b1;
            meta_wa = clr_cnt_ff;
            cls_we  = (PTR_W'(clr_cnt_ff) < PTR_W'(NUM_CLASSES));
            cls_wa  = CLS_W'(clr_cnt_ff);
            cls_wd  = '{head: NIL, tail: NIL, size: '0};
            clr_cnt_in = clr_cnt_ff + SLOT_W'(1);
            if (clr_cnt_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.operation;
               idx_in   = SLOT_W'(req_bus.item_index);
               icls_in  = CLS_W'(req_bus.item_class);
               now_in   = TIME_BITS'(req_bus.now_time);
               state_in = S_RD;
            end
         end
         S_RD: begin
            rc_in    = meta_rd.linked ? meta_rd.cls : icls_ff;
            old_in   = meta_rd.stamp < limit;
            state_in = S_CLS;
         end
         S_CLS: begin
            base_in = do_take ? taken : cls_rd;
            res_in  = base_in;
            case (op_ff)
               OP_LINK:   res_status_in = meta_rd.linked ? ST_ALREADY : ST_DONE;
               OP_UNLINK: res_status_in = meta_rd.linked ? ST_DONE : ST_NOT_LINKED;
               OP_TOUCH:  res_status_in = !meta_rd.linked ? ST_NOT_LINKED :
                                          (old_ff ? ST_DONE : ST_SKIPPED);
               default:   res_status_in = ST_DONE;
            endcase
            if (op_ff == OP_LINK && !meta_rd.linked) begin
               rc_in = icls_ff;
            end
            if (do_take) begin
               meta_we = 1'b1;
               meta_wd = '{linked: 1'b0, cls: meta_rd.cls, stamp: meta_rd.stamp};
               cls_we  = 1'b1;
               cls_wd  = taken;
               next_we = (prev_rd < NIL);
               next_wa = SLOT_W'(prev_rd);
               next_wd = next_rd;
               prev_we = (next_rd < NIL);
               prev_wa = SLOT_W'(next_rd);
               prev_wd = prev_rd;
            end
            state_in = do_put ? S_PUT : S_OUT;
         end
         S_PUT: begin
            meta_we = 1'b1;
            meta_wd = '{linked: 1'b1, cls: rc_ff, stamp: now_ff};
            next_we = 1'b1;
            prev_we = 1'b1;
            cls_we  = 1'b1;
            res_in  = put_val;
            state_in = S_PUT2;
         end
         S_PUT2: begin
            prev_we  = (base_ff.head < NIL);
            prev_wa  = SLOT_W'(base_ff.head);
            prev_wd  = s_ptr;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_in        = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cnt_ff   <= '0;
         interval_ff  <= INTERVAL_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      icls_ff       <= icls_in;
      now_ff        <= now_in;
      rc_ff         <= rc_in;
      old_ff        <= old_in;
      base_ff       <= base_in;
      res_status_ff <= res_status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ff        <= rsp_in;
   end

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while an item is in flight");

   a_head_has_no_prev: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLS && meta_rd.linked && cls_rd.head == s_ptr)
      |-> (prev_rd == NIL))
      else $error("class head slot has a predecessor");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the output step");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |-> (base_ff.size < PTR_W'(NUM_SLOTS)))
      else $error("class count overflows slot pool");
`endif
endmodule

[bench/pclru_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pclru_checker
// watches request and response beats, predicts per-class lru list results
// and compares them field by field; counts failures for the bench top
// ----------------------------------------------------------------------------
module pclru_checker
   import pclru_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   pclru_req_if                   req_mon,
   pclru_rsp_if                   rsp_mon,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic                   csr_pready,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output int                     fail_count,
   output int                     pending_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OUT_W-1:0]    head;
      logic [OUT_W-1:0]    tail;
      logic [OUT_W-1:0]    count;
   } list_summary_type;

   logic [PTR_W-1:0]     nxt [NUM_SLOTS];
   logic [PTR_W-1:0]     prv [NUM_SLOTS];
   logic [CLS_W-1:0]     home [NUM_SLOTS];
   logic [TIME_BITS-1:0] stamp [NUM_SLOTS];
   logic                 linked [NUM_SLOTS];
   logic [PTR_W-1:0]     chead [NUM_CLASSES];
   logic [PTR_W-1:0]     ctail [NUM_CLASSES];
   logic [PTR_W-1:0]     csize [NUM_CLASSES];
   logic [31:0]          interval;
   list_summary_type     summary_q [$];

   function automatic void insert_head(input int s, input int c);
      logic [PTR_W-1:0] h;
      h = chead[c];
      home[s] = CLS_W'(c);
      prv[s] = NIL;
      nxt[s] = h;
      if (h < NIL) prv[h] = PTR_W'(s);
      chead[c] = PTR_W'(s);
      if (ctail[c] >= NIL) ctail[c] = PTR_W'(s);
      csize[c] = csize[c] + PTR_W'(1);
      linked[s] = 1'b1;
   endfunction

   function automatic void remove_slot(input int s);
      int c;
      logic [PTR_W-1:0] n, p;
      c = home[s];
      n = nxt[s];
      p = prv[s];
      if (chead[c] == PTR_W'(s)) chead[c] = n;
      if (ctail[c] == PTR_W'(s)) ctail[c] = p;
      if (n < NIL) prv[n] = p;
      if (p < NIL) nxt[p] = n;
      if (csize[c] > 0) csize[c] = csize[c] - PTR_W'(1);
      linked[s] = 1'b0;
   endfunction

   function automatic list_summary_type apply_op(input logic [OP_W-1:0] op,
         input logic [IDX_W-1:0] idx, input logic [ICLS_W-1:0] icls,
         input logic [NOW_W-1:0] now);
      list_summary_type r;
      int s, rc;
      logic [TIME_BITS-1:0] lim;
      s = idx;
      rc = icls;
      r.status = ST_DONE;
      if (linked[s]) rc = home[s];
      if (op == OP_LINK) begin
         if (linked[s]) r.status = ST_ALREADY;
         else begin
            stamp[s] = now;
            insert_head(s, icls);
            rc = icls;
         end
      end else if (op == OP_UNLINK) begin
         if (linked[s]) remove_slot(s);
         else r.status = ST_NOT_LINKED;
      end else if (op == OP_TOUCH) begin
         if (!linked[s]) r.status = ST_NOT_LINKED;
         else begin
            lim = now - interval;
            if (stamp[s] < lim) begin
               remove_slot(s);
               stamp[s] = now;
               insert_head(s, rc);
            end else begin
               r.status = ST_SKIPPED;
            end
         end
      end
      r.head = chead[rc];
      r.tail = ctail[rc];
      r.count = csize[rc];
      return r;
   endfunction

   always @(posedge clock) begin
      list_summary_type want, got;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) linked[i] = 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            chead[i] = NIL;
            ctail[i] = NIL;
            csize[i] = '0;
         end
         interval = INTERVAL_RST;
         summary_q.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
               && csr_paddr == ADDR_UPDATE_INTERVAL)
            interval = csr_pwdata;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.status, rsp_mon.list_head, rsp_mon.list_tail,
                    rsp_mon.list_count};
            if (summary_q.size() == 0) begin
               $display("%0t unexpected beat: expected none, actual %h", $time, got);
               fail_count++;
            end else begin
               want = summary_q.pop_front();
               if (got.status != want.status) begin
                  $display("%0t status: expected %0d, actual %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
               if (got.head != want.head) begin
                  $display("%0t list_head: expected %0d, actual %0d",
                           $time, want.head, got.head);
                  fail_count++;
               end
               if (got.tail != want.tail) begin
                  $display("%0t list_tail: expected %0d, actual %0d",
                           $time, want.tail, got.tail);
                  fail_count++;
               end
               if (got.count != want.count) begin
                  $display("%0t list_count: expected %0d, actual %0d",
                           $time, want.count, got.count);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            summary_q.push_back(apply_op(req_mon.operation, req_mon.item_index,
                                         req_mon.item_class, req_mon.now_time));
         pending_count = summary_q.size();
      end
   end

endmodule

[bench/tb_per_class_lru_list_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_class_lru_list_top
// drives directed and random list operations with bursty idling and a stalling receiver,
// rewrites the update interval between phases and reports the verdict
// ----------------------------------------------------------------------------
module tb_per_class_lru_list_top;
   import pclru_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata, csr_prdata;
   int                     fail_count, pending_count;
   int                     hold_off;
   logic [NOW_W-1:0]       clock_now;
   logic                   live [NUM_SLOTS];

   pclru_req_if req_bus ();
   pclru_rsp_if rsp_bus ();

   per_class_lru_list_top uut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pclru_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_bus), .rsp_mon(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("per_class_lru_list_top: mismatch");
      $finish;
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      hold_off = 0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_bus.ready <= 1'b0;
         end else if (($time / 4000) % 3 == 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   task automatic csr_write(input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_UPDATE_INTERVAL;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
         input logic [ICLS_W-1:0] cls, input logic [NOW_W-1:0] now);
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.item_index <= idx;
      req_bus.item_class <= cls;
      req_bus.now_time <= now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (op == OP_LINK) live[idx] = 1'b1;
      if (op == OP_UNLINK) live[idx] = 1'b0;
   endtask

   task automatic idle_gap();
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic random_op(input int pool);
      logic [IDX_W-1:0] idx;
      int pick;
      logic [OP_W-1:0] op;
      idx = IDX_W'($urandom_range(0, pool - 1));
      pick = $urandom_range(0, 99);
      if (pick < 3) idx = IDX_W'($urandom);
      if (pick < 35) op = live[idx] ? OP_UNLINK : OP_LINK;
      else if (pick < 75) op = OP_TOUCH;
      else if (pick < 97) op = OP_W'($urandom_range(0, 2));
      else op = OP_UNUSED;
      clock_now = clock_now + NOW_W'($urandom_range(0, 40));
      send_op(op, idx, ICLS_W'($urandom_range(0, 63)),
              ($urandom_range(0, 19) == 0) ? NOW_W'($urandom) : clock_now);
   endtask

   initial begin
      logic [31:0] intervals [5];
      intervals = '{32'd0, 32'd60, 32'd25, 32'hFFFF_FFFF, 32'h8000_0000};
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_bus.valid = 1'b0; req_bus.operation = '0; req_bus.item_index = '0;
      req_bus.item_class = '0; req_bus.now_time = '0;
      clock_now = 32'd1000;
      for (int i = 0; i < NUM_SLOTS; i++) live[i] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, errors, touches, unused code
      send_op(OP_LINK, 10'd0, 6'd0, 32'd0);
      send_op(OP_LINK, 10'd1023, 6'd63, 32'hFFFF_FFFF);
      send_op(OP_LINK, 10'd0, 6'd5, 32'd1);
      send_op(OP_LINK, 10'd5, 6'd0, 32'd100);
      send_op(OP_LINK, 10'd6, 6'd0, 32'd100);
      send_op(OP_TOUCH, 10'd0, 6'd9, 32'd70);
      send_op(OP_TOUCH, 10'd0, 6'd9, 32'd61);
      send_op(OP_TOUCH, 10'd5, 6'd0, 32'd150);
      send_op(OP_TOUCH, 10'd1023, 6'd0, 32'd10);
      send_op(OP_TOUCH, 10'd200, 6'd3, 32'd500);
      send_op(OP_UNLINK, 10'd300, 6'd42, 32'd0);
      send_op(OP_UNLINK, 10'd6, 6'd0, 32'd0);
      send_op(OP_UNUSED, 10'd0, 6'd0, 32'd0);
      send_op(OP_UNUSED, 10'd512, 6'h2A, 32'h5555_5555);
      send_op(OP_UNLINK, 10'd0, 6'd0, 32'd0);
      send_op(OP_UNLINK, 10'd5, 6'd0, 32'd0);
      send_op(OP_UNLINK, 10'd1023, 6'd0, 32'd0);
      req_bus.valid <= 1'b0;
      wait_drained();

      for (int ph = 0; ph < 5; ph++) begin
         csr_write(intervals[ph]);
         for (int n = 0; n < 290; n++) begin
            if (ph == 2 && n == 100) hold_off = 300;
            random_op((n % 50 < 40) ? 24 : 1024);
            if ($urandom_range(0, 7) == 0) idle_gap();
         end
         req_bus.valid <= 1'b0;
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("per_class_lru_list_top: match");
      else
         $display("per_class_lru_list_top: mismatch");
      $finish;
   end

endmodule
